// ===== hdl/cubic_spline_point_eval_top_defines.svh =====
// assertion macros used by the checker file
`ifndef CUBIC_SPLINE_POINT_EVAL_TOP_DEFINES_SVH
`define CUBIC_SPLINE_POINT_EVAL_TOP_DEFINES_SVH

// concurrent assertion, disabled while reset is asserted
`define CSPE_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cspe assertion failed");

// concurrent assertion, checked at every rising edge
`define CSPE_ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cspe assertion failed");

`endif

// ===== hdl/cspe_pkg.sv =====
// shared widths, types and constants of the cubic spline point evaluator
`default_nettype none
package cspe_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int T_FRAC_BITS = 16;

  localparam int TW = T_FRAC_BITS + 1;        // t, t^2, t^3
  localparam int WW = T_FRAC_BITS + 6;        // signed basis weights
  localparam int PW = COORD_WIDTH + WW;       // one product
  localparam int AW = PW + 2;                 // sum of four products
  localparam int RS = T_FRAC_BITS + 1;        // final rounding shift

  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [2*TW-1:0] T_HALF = {{(2*TW-T_FRAC_BITS){1'b0}},
                                        1'b1, {(T_FRAC_BITS-1){1'b0}}};
  localparam logic signed [WW-1:0] W_ONE = {{(WW-TW){1'b0}}, T_ONE};
  localparam logic signed [AW-1:0] ACC_HALF = {{(AW-RS){1'b0}}, 1'b1,
                                               {(RS-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    BASIS_HERMITE = 2'd0,
    BASIS_BEZIER  = 2'd1,
    BASIS_CATROM  = 2'd2
  } basis_e;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } pts_t;

  typedef struct packed {
    logic          valid;
    logic [TW-1:0] t;
    logic [TW-1:0] t2;
    logic [TW-1:0] t3;
  } tpow_t;

  typedef struct packed {
    logic                  valid;
    logic [3:0][WW-1:0]    w;
  } wgt_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    logic   sat;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/cspe_tpow.sv =====
// two pipeline stages forming the clamped t, t squared and t cubed
`default_nettype none
module cspe_tpow
  import cspe_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [TW-1:0] t_i,
  output tpow_t         pow_o
);

  logic          v1_q, v1_d;
  logic [TW-1:0] t1_q, t1_d;
  logic [TW-1:0] sq1_q, sq1_d;
  logic [2*TW-1:0] sq_full, cu_full;
  logic [TW-1:0] tc;
  tpow_t         pow_q, pow_d;

  always_comb begin
    tc      = (t_i > T_ONE) ? T_ONE : t_i;
    sq_full = (2*TW)'(tc) * (2*TW)'(tc) + T_HALF;
    v1_d    = valid_i;
    t1_d    = tc;
    sq1_d   = TW'(sq_full >> T_FRAC_BITS);
  end

  always_comb begin
    cu_full     = (2*TW)'(sq1_q) * (2*TW)'(t1_q) + T_HALF;
    pow_d.valid = v1_q;
    pow_d.t     = t1_q;
    pow_d.t2    = sq1_q;
    pow_d.t3    = TW'(cu_full >> T_FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      pow_q <= '0;
    end else begin
      v1_q  <= v1_d;
      pow_q <= pow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= t1_d;
    sq1_q <= sq1_d;
  end

  assign pow_o = pow_q;

endmodule
`default_nettype wire

// ===== hdl/cspe_weights.sv =====
// basis weight stage: four weights at scale 2^(F+1) for the selected basis
`default_nettype none
module cspe_weights
  import cspe_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  tpow_t  pow_i,
  input  basis_e basis_i,
  output wgt_t   wgt_o
);

  logic signed [WW-1:0] a1, a2, a6;
  logic signed [WW-1:0] b1, b2, b4, b5, b6, b12;
  logic signed [WW-1:0] c1, c2, c3, c4, c6;
  logic signed [WW-1:0] one2;
  wgt_t wgt_q, wgt_d;

  always_comb begin
    a1  = $signed({{(WW-TW){1'b0}}, pow_i.t});
    b1  = $signed({{(WW-TW){1'b0}}, pow_i.t2});
    c1  = $signed({{(WW-TW){1'b0}}, pow_i.t3});
    a2  = a1 <<< 1;
    a6  = (a1 <<< 2) + a2;
    b2  = b1 <<< 1;
    b4  = b1 <<< 2;
    b5  = b4 + b1;
    b6  = b4 + b2;
    b12 = b6 <<< 1;
    c2  = c1 <<< 1;
    c3  = c2 + c1;
    c4  = c1 <<< 2;
    c6  = c3 <<< 1;
    one2 = W_ONE <<< 1;

    wgt_d.valid = pow_i.valid;
    case (basis_i)
      BASIS_HERMITE: begin
        wgt_d.w[0] = c4 - b6 + one2;
        wgt_d.w[1] = c2 - b4 + a2;
        wgt_d.w[2] = b6 - c4;
        wgt_d.w[3] = c2 - b2;
      end
      BASIS_BEZIER: begin
        wgt_d.w[0] = b6 - c2 - a6 + one2;
        wgt_d.w[1] = c6 - b12 + a6;
        wgt_d.w[2] = b6 - c6;
        wgt_d.w[3] = c2;
      end
      BASIS_CATROM: begin
        wgt_d.w[0] = b2 - a1 - c1;
        wgt_d.w[1] = one2 - b5 + c3;
        wgt_d.w[2] = a1 + b4 - c3;
        wgt_d.w[3] = c1 - b1;
      end
      default: begin
        // unused basis code: zero weights give a zero point, no clamp
        wgt_d.w = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wgt_q <= '0;
    end else begin
      wgt_q <= wgt_d;
    end
  end

  assign wgt_o = wgt_q;

endmodule
`default_nettype wire

// ===== hdl/cspe_dot.sv =====
// product, sum and round/saturate stages of the weighted coordinate sums
`default_nettype none
module cspe_dot
  import cspe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  wgt_t wgt_i,
  input  pts_t pts_i,
  output res_t res_o
);

  logic signed [PW-1:0] px_q [4];
  logic signed [PW-1:0] py_q [4];
  logic signed [PW-1:0] px_d [4];
  logic signed [PW-1:0] py_d [4];
  logic                 vp_q;
  logic signed [AW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic                 vs_q;
  logic signed [AW-1:0] shx, shy;
  logic [AW-COORD_WIDTH:0] topx, topy;
  logic                 okx, oky;
  res_t                 res_q, res_d;

  // stage: eight products in parallel
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px_d[k] = PW'($signed(pts_i.x[k])) * PW'($signed(wgt_i.w[k]));
      py_d[k] = PW'($signed(pts_i.y[k])) * PW'($signed(wgt_i.w[k]));
    end
  end

  // stage: sums with the rounding half folded in
  always_comb begin
    sx_d = AW'(px_q[0]) + AW'(px_q[1]) + AW'(px_q[2]) + AW'(px_q[3]) + ACC_HALF;
    sy_d = AW'(py_q[0]) + AW'(py_q[1]) + AW'(py_q[2]) + AW'(py_q[3]) + ACC_HALF;
  end

  // stage: shift and clamp to the coordinate range
  always_comb begin
    shx  = sx_q >>> RS;
    shy  = sy_q >>> RS;
    topx = shx[AW-1:COORD_WIDTH-1];
    topy = shy[AW-1:COORD_WIDTH-1];
    okx  = (&topx) || !(|topx);
    oky  = (&topy) || !(|topy);
    res_d.valid = vs_q;
    res_d.x     = okx ? shx[COORD_WIDTH-1:0] : (sx_q[AW-1] ? COORD_MIN : COORD_MAX);
    res_d.y     = oky ? shy[COORD_WIDTH-1:0] : (sy_q[AW-1] ? COORD_MIN : COORD_MAX);
    res_d.sat   = !okx || !oky;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q  <= 1'b0;
      vs_q  <= 1'b0;
      res_q <= '0;
    end else begin
      vp_q  <= wgt_i.valid;
      vs_q  <= vp_q;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    sx_q <= sx_d;
    sy_q <= sy_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== hdl/cubic_spline_point_eval_top.sv =====
// top level of the cubic spline point evaluator
//
//   channel   direction  handshake                     payload
//   -------   ---------  ----------------------------  -----------------------------
//   command   in         start, busy                   p0..p3 x/y, t_param
//   result    out        out_valid_o strobe            out_x, out_y, saturated
//   config    in         cfg_valid_i, cfg_ready_o      cfg_data_i (basis_mode)
//
// one transaction per clock; each point leaves once it has passed every stage
// pipeline stages in order: t^2 multiply, t^3 multiply, weight stage,
// coordinate products, four-way sum, round and clamp stage
// busy stays low: the pipeline never holds, the result is a one-cycle strobe
// reset clears the stage valid bits and sets basis_mode to hermite
// config is taken in any cycle and applies to transactions at the weight stage
`default_nettype none
module cubic_spline_point_eval_top
  import cspe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_WIDTH-1:0] p0_x_i,
  input  logic [COORD_WIDTH-1:0] p0_y_i,
  input  logic [COORD_WIDTH-1:0] p1_x_i,
  input  logic [COORD_WIDTH-1:0] p1_y_i,
  input  logic [COORD_WIDTH-1:0] p2_x_i,
  input  logic [COORD_WIDTH-1:0] p2_y_i,
  input  logic [COORD_WIDTH-1:0] p3_x_i,
  input  logic [COORD_WIDTH-1:0] p3_y_i,
  input  logic [TW-1:0]         t_param_i,
  // result channel
  output logic                  out_valid_o,
  output logic [COORD_WIDTH-1:0] out_x_o,
  output logic [COORD_WIDTH-1:0] out_y_o,
  output logic                  saturated_o,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_data_i
);

  logic   accept;
  basis_e basis_q, basis_d;
  pts_t   pts_in;
  pts_t   pts_q [3];    // control points ride alongside the t and weight stages
  tpow_t  pow;
  wgt_t   wgt;
  res_t   res;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // basis register
  always_comb begin
    basis_d = basis_q;
    if (cfg_valid_i && cfg_ready_o) begin
      basis_d = basis_e'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q <= BASIS_HERMITE;
    end else begin
      basis_q <= basis_d;
    end
  end

  // control point delay line, payload only; validity comes from the stage bits
  always_comb begin
    pts_in.x[0] = p0_x_i;
    pts_in.y[0] = p0_y_i;
    pts_in.x[1] = p1_x_i;
    pts_in.y[1] = p1_y_i;
    pts_in.x[2] = p2_x_i;
    pts_in.y[2] = p2_y_i;
    pts_in.x[3] = p3_x_i;
    pts_in.y[3] = p3_y_i;
  end

  always_ff @(posedge clk_i) begin
    pts_q[0] <= pts_in;
    pts_q[1] <= pts_q[0];
    pts_q[2] <= pts_q[1];
  end

  cspe_tpow u_tpow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .t_i     (t_param_i),
    .pow_o   (pow)
  );

  cspe_weights u_weights (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pow_i   (pow),
    .basis_i (basis_q),
    .wgt_o   (wgt)
  );

  cspe_dot u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wgt_i  (wgt),
    .pts_i  (pts_q[2]),
    .res_o  (res)
  );

  assign out_valid_o = res.valid;
  assign out_x_o     = res.x;
  assign out_y_o     = res.y;
  assign saturated_o = res.sat;

endmodule
`default_nettype wire

// ===== hdl/cspe_checker.sv =====
// port-level checker of the evaluator and its bind to the top level
`default_nettype none
`include "cubic_spline_point_eval_top_defines.svh"
module cspe_checker
  import cspe_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid_o,
  input logic [COORD_WIDTH-1:0] out_x_o,
  input logic [COORD_WIDTH-1:0] out_y_o,
  input logic                   saturated_o
);

  // every taken transaction gives a result strobe at the pipeline depth
  `CSPE_ASSERT_RST(a_in_to_out, clk_i, rst_ni, (start && !busy) |-> ##6 out_valid_o)

  // no strobe without a transaction at the pipeline depth before it
  `CSPE_ASSERT_RST(a_out_from_in, clk_i, rst_ni, out_valid_o |-> $past(start && !busy, 6))

  // a clamp flag always comes with a coordinate at a range limit
  `CSPE_ASSERT_ANY(a_sat_at_limit, clk_i,
    (out_valid_o && saturated_o) |->
      (out_x_o == COORD_MAX || out_x_o == COORD_MIN ||
       out_y_o == COORD_MAX || out_y_o == COORD_MIN))

endmodule

bind cubic_spline_point_eval_top cspe_checker u_cspe_checker (.*);
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the cubic spline point evaluator
module testbench;
  import cspe_pkg::*;

  // one curve point request: control vectors p0..p3 and the parameter t
  typedef struct packed {
    coord_t [3:0]  cx;
    coord_t [3:0]  cy;
    logic [TW-1:0] t;
  } spline_cmd_t;

  // one evaluated point as it leaves the block
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   sat;
  } spline_pt_t;

  // directed stimulus row; typed rows carry their expected point
  typedef struct {
    logic [1:0]  mode;
    spline_cmd_t cmd;
    bit          typed;
    spline_pt_t  pt;
  } dir_row_t;

  // basis code that the package enum leaves out: block outputs zeros
  localparam logic [1:0] BASIS_NONE = 2'd3;

  localparam int PIPE_LAT   = 6;     // cycles from command to result strobe
  localparam int MAX_IDLE   = 2000;  // watchdog: cycles with no transaction
  localparam int MAX_REPORT = 10;
  localparam int PHASES     = 10;
  localparam int PHASE_PTS  = 53;

  localparam coord_t MX = COORD_MAX;
  localparam coord_t MN = COORD_MIN;
  localparam coord_t Q1 = 32'h0001_0000;   // +1.0
  localparam coord_t QN = 32'hFFFF_0000;   // -1.0
  localparam logic [TW-1:0] T_MID = 17'h0_8000;  // 0.5
  localparam logic [TW-1:0] T_TOP = 17'h1_FFFF;  // largest code, clamps to 1.0

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        out_valid_o;
  coord_t      out_x_o;
  coord_t      out_y_o;
  logic        saturated_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;

  // command currently on the input ports, plus its typed expectation if any
  spline_cmd_t cmd_drv;
  bit          drv_typed;
  spline_pt_t  drv_pt;

  logic [1:0]  basis_now;          // basis the block is expected to hold
  spline_pt_t  pt_expect_q[$];     // points still owed by the block, oldest first
  dir_row_t    dir_rows[$];
  int          fail_cnt;
  int          idle_cycles;

  cubic_spline_point_eval_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .p0_x_i      (cmd_drv.cx[0]),
    .p0_y_i      (cmd_drv.cy[0]),
    .p1_x_i      (cmd_drv.cx[1]),
    .p1_y_i      (cmd_drv.cy[1]),
    .p2_x_i      (cmd_drv.cx[2]),
    .p2_y_i      (cmd_drv.cy[2]),
    .p3_x_i      (cmd_drv.cx[3]),
    .p3_y_i      (cmd_drv.cy[3]),
    .t_param_i   (cmd_drv.t),
    .out_valid_o (out_valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .saturated_o (saturated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // point predictor
  // ---------------------------------------------------------------------------

  // weighted sum is at scale 2^(F+1): round half up, drop F+1 bits, clamp;
  // top bit of the return value flags a clamp
  function automatic logic [COORD_WIDTH:0] round_clamp(longint acc);
    longint v;
    longint hi;
    longint lo;
    hi = longint'(COORD_MAX);
    lo = -hi - 1;
    v  = (acc + (longint'(1) << T_FRAC_BITS)) >>> (T_FRAC_BITS + 1);
    if (v > hi) return {1'b1, COORD_MAX};
    if (v < lo) return {1'b1, COORD_MIN};
    return {1'b0, v[COORD_WIDTH-1:0]};
  endfunction

  function automatic spline_pt_t eval_spline_point(logic [1:0] mode, spline_cmd_t c);
    longint tt;
    longint t2;
    longint t3;
    longint one;
    longint half;
    longint accx;
    longint accy;
    longint w [4];
    logic [COORD_WIDTH:0] rx;
    logic [COORD_WIDTH:0] ry;
    spline_pt_t r;
    int k;
    one  = longint'(1) << T_FRAC_BITS;
    half = one >>> 1;
    // t above one is treated as exactly one
    tt = (c.t > T_ONE) ? one : longint'(c.t);
    t2 = (tt * tt + half) >>> T_FRAC_BITS;
    t3 = (t2 * tt + half) >>> T_FRAC_BITS;
    // weights carry one extra fraction bit so catmull-rom halves stay exact
    case (mode)
      BASIS_HERMITE: begin
        w[0] = 2 * (2 * t3 - 3 * t2 + one);
        w[1] = 2 * (t3 - 2 * t2 + tt);
        w[2] = 2 * (-2 * t3 + 3 * t2);
        w[3] = 2 * (t3 - t2);
      end
      BASIS_BEZIER: begin
        w[0] = 2 * (-t3 + 3 * t2 - 3 * tt + one);
        w[1] = 2 * (3 * t3 - 6 * t2 + 3 * tt);
        w[2] = 2 * (-3 * t3 + 3 * t2);
        w[3] = 2 * t3;
      end
      BASIS_CATROM: begin
        w[0] = -tt + 2 * t2 - t3;
        w[1] = 2 * one - 5 * t2 + 3 * t3;
        w[2] = tt + 4 * t2 - 3 * t3;
        w[3] = -t2 + t3;
      end
      default: return '0;  // unused basis code: zero point, no clamp
    endcase
    accx = 0;
    accy = 0;
    for (k = 0; k < 4; k++) begin
      accx += longint'($signed(c.cx[k])) * w[k];
      accy += longint'($signed(c.cy[k])) * w[k];
    end
    rx    = round_clamp(accx);
    ry    = round_clamp(accy);
    r.x   = rx[COORD_WIDTH-1:0];
    r.y   = ry[COORD_WIDTH-1:0];
    r.sat = rx[COORD_WIDTH] | ry[COORD_WIDTH];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_fail(string what, spline_pt_t want, spline_pt_t got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORT)
      $display("%0t %s: expected x=%h y=%h sat=%b, got x=%h y=%h sat=%b", $realtime, what,
               want.x, want.y, want.sat, got.x, got.y, got.sat);
  endtask

  always @(posedge clk_i) begin : result_mon
    spline_pt_t got;
    spline_pt_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      // command transaction: record what the block owes for it
      if (start && busy === 1'b0) begin
        pt_expect_q.push_back(drv_typed ? drv_pt : eval_spline_point(basis_now, cmd_drv));
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o === 1'b1)
        moved = 1'b1;
      // result strobe: the receiver has no way to stall, so take it now
      if (out_valid_o === 1'b1) begin
        moved   = 1'b1;
        got.x   = out_x_o;
        got.y   = out_y_o;
        got.sat = saturated_o;
        if (pt_expect_q.size() == 0) begin
          report_fail("result with nothing pending", got, got);
        end else begin
          want = pt_expect_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.sat !== want.sat)
            report_fail("point mismatch", want, got);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= MAX_IDLE) begin
      $display("timeout: no transaction for %0d cycles", MAX_IDLE);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, some short pauses, the odd long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // extremes, full-range values (often clamp) and small values (rarely clamp)
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return MX;
      1:       return MN;
      2, 3, 4: return $urandom;
      default: return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  // t in [0,1] most of the time, any 17-bit code now and then
  function automatic logic [TW-1:0] rand_t();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return T_ONE;
      2:       return TW'($urandom_range(0, 17'h1_FFFF));
      default: return TW'($urandom_range(0, 17'h1_0000));
    endcase
  endfunction

  function automatic spline_cmd_t rand_cmd();
    spline_cmd_t c;
    int k;
    for (k = 0; k < 4; k++) begin
      c.cx[k] = rand_coord();
      c.cy[k] = rand_coord();
    end
    c.t = rand_t();
    return c;
  endfunction

  function automatic void add_row(logic [1:0] mode, coord_t x0, coord_t y0, coord_t x1,
                                  coord_t y1, coord_t x2, coord_t y2, coord_t x3, coord_t y3,
                                  logic [TW-1:0] t, bit typed, coord_t ex, coord_t ey,
                                  logic es);
    dir_row_t r;
    r.mode   = mode;
    r.cmd.cx = {x3, x2, x1, x0};
    r.cmd.cy = {y3, y2, y1, y0};
    r.cmd.t  = t;
    r.typed  = typed;
    r.pt.x   = ex;
    r.pt.y   = ey;
    r.pt.sat = es;
    dir_rows.push_back(r);
  endfunction

  // present one command and hold it until the block takes it
  task automatic send_point(spline_cmd_t c, bit typed, spline_pt_t pt, bit gappy);
    int g;
    g = gappy ? gap_len() : 0;
    repeat (g) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start     <= 1'b1;
    cmd_drv   <= c;
    drv_typed <= typed;
    drv_pt    <= pt;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // stop issuing and let every pending point come out of the pipeline
  task automatic settle();
    @(negedge clk_i) start <= 1'b0;
    while (pt_expect_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic write_basis(logic [1:0] mode);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    basis_now = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int ph;
    int n;
    logic [1:0] m;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_drv     = '0;
    drv_typed   = 1'b0;
    drv_pt      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = BASIS_HERMITE;
    basis_now   = BASIS_HERMITE;
    fail_cnt    = 0;
    idle_cycles = 0;

    // hermite rows run on the reset basis, no write ahead of them
    // t = 0 gives the start point, t = 1 (or above) the end point
    add_row(BASIS_HERMITE, Q1, QN, 32'h0003_0000, 32'h0002_8000, 32'h0123_4567,
            32'hFEDC_BA98, 32'h0000_4000, 32'hFFF0_0000, '0, 1, Q1, QN, 0);
    add_row(BASIS_HERMITE, Q1, QN, 32'h0003_0000, 32'h0002_8000, 32'h0123_4567,
            32'hFEDC_BA98, 32'h0000_4000, 32'hFFF0_0000, T_ONE, 1,
            32'h0123_4567, 32'hFEDC_BA98, 0);
    add_row(BASIS_HERMITE, Q1, QN, 32'h0003_0000, 32'h0002_8000, 32'h0123_4567,
            32'hFEDC_BA98, 32'h0000_4000, 32'hFFF0_0000, T_TOP, 1,
            32'h0123_4567, 32'hFEDC_BA98, 0);
    add_row(BASIS_HERMITE, MX, MN, 32'h1234_0000, 32'h8765_4321, 32'h7FFF_0000,
            32'h0000_FFFF, MN, MX, '0, 1, MX, MN, 0);
    // tangent pushes the midpoint past full scale on both axes
    add_row(BASIS_HERMITE, MX, MN, MX, MN, MX, MN, '0, '0, T_MID, 1, MX, MN, 1);
    // end points at full scale, zero tangents: lands exactly on the rail
    add_row(BASIS_HERMITE, MX, MN, '0, '0, MX, MN, '0, '0, T_MID, 1, MX, MN, 0);
    add_row(BASIS_HERMITE, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, 17'h0_4000,
            0, '0, '0, 0);
    add_row(BASIS_HERMITE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0002_0000, 32'hFFFE_0000,
            32'h0000_8000, 32'hFFFF_8000, 32'hFFF8_0000, 32'h0008_0000, 17'h0_FFFF,
            0, '0, '0, 0);
    // bezier: end points at t = 0 and t = 1, weights sum to one
    add_row(BASIS_BEZIER, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, '0, 1,
            32'h0010_0000, 32'hFFE0_0000, 0);
    add_row(BASIS_BEZIER, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, T_ONE, 1,
            32'h0005_5555, 32'hFFFF_FFFF, 0);
    add_row(BASIS_BEZIER, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, 17'h1_0001, 1,
            32'h0005_5555, 32'hFFFF_FFFF, 0);
    add_row(BASIS_BEZIER, MX, MN, MX, MN, MX, MN, MX, MN, T_MID, 1, MX, MN, 0);
    add_row(BASIS_BEZIER, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, 17'h0_5555,
            0, '0, '0, 0);
    add_row(BASIS_BEZIER, 32'hDEAD_BEEF, 32'h1357_9BDF, 32'h2468_ACE0, 32'hFDB9_7531,
            MX, MN, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 17'h0_0001, 0, '0, '0, 0);
    // catmull-rom: the curve runs from p1 to p2
    add_row(BASIS_CATROM, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, '0, 1,
            32'h7000_0000, 32'h9000_0000, 0);
    add_row(BASIS_CATROM, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, T_ONE, 1,
            32'h8000_0001, 32'h0000_0001, 0);
    add_row(BASIS_CATROM, MX, MN, MX, MN, MX, MN, MX, MN, T_MID, 1, MX, MN, 0);
    // outer points pulled the other way: overshoot clamps both axes
    add_row(BASIS_CATROM, MN, MX, MX, MN, MX, MN, MN, MX, T_MID, 1, MX, MN, 1);
    add_row(BASIS_CATROM, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, 17'h0_3000,
            0, '0, '0, 0);
    // unused basis code always yields a zero point
    add_row(BASIS_NONE, MX, MX, MX, MX, MX, MX, MX, MX, T_MID, 1, '0, '0, 0);
    add_row(BASIS_NONE, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, T_TOP, 1,
            '0, '0, 0);
    // back to hermite by an explicit write
    add_row(BASIS_HERMITE, 32'h0010_0000, 32'hFFE0_0000, 32'h7000_0000, 32'h9000_0000,
            32'h8000_0001, 32'h0000_0001, 32'h0005_5555, 32'hFFFF_FFFF, 17'h0_2AAA,
            0, '0, '0, 0);
    add_row(BASIS_HERMITE, MX, MX, MN, MN, '0, '0, MX, MN, 17'h0_C000, 0, '0, '0, 0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed rows, basis changed only with the pipeline drained
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != basis_now) begin
        settle();
        write_basis(dir_rows[i].mode);
      end
      send_point(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].pt, 1'b0);
    end

    // random phases: every basis code first, then random picks;
    // two phases run back to back with no pauses
    for (ph = 0; ph < PHASES; ph++) begin
      m = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
      settle();
      write_basis(m);
      for (n = 0; n < PHASE_PTS; n++)
        send_point(rand_cmd(), 1'b0, '0, (ph != 2 && ph != 7));
    end

    settle();
    if (fail_cnt == 0 && pt_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
